[rtl/core/radix_converter_decimal_coded_top_macros.svh]
// Assertion macros for the radix converter checker.
// Each macro expands to one labeled concurrent assertion on a clock and a reset.
`ifndef RADIX_CONVERTER_DECIMAL_CODED_TOP_MACROS_SVH
`define RADIX_CONVERTER_DECIMAL_CODED_TOP_MACROS_SVH

// Condition and consequence in the same cycle.
`define RCD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("radix converter assertion failed");

// Consequence in the cycle after the condition.
`define RCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("radix converter assertion failed");

`endif

[rtl/core/rcd_pkg.sv]
// Shared widths, register indexes, control structs and helpers of the radix converter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rcd_pkg;

   localparam int IN_W       = 30;
   localparam int OUT_W      = 60;
   localparam int BASE_W     = 4;
   localparam int DIGIT_W    = 4;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
   localparam int VAL_W      = 30;
   localparam int DIV_CHUNK  = 4;
   localparam int DIV_W      = 32;
   localparam int DIV_STEPS  = DIV_W / DIV_CHUNK;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BASE = 1'd1;

   localparam logic [BASE_W-1:0] BASE_MIN          = 4'd2;
   localparam logic [BASE_W-1:0] BASE_MAX          = 4'd10;
   localparam logic [BASE_W-1:0] SOURCE_BASE_RESET = 4'd10;
   localparam logic [BASE_W-1:0] TARGET_BASE_RESET = 4'd2;

   localparam logic [OUT_W-1:0] RESULT_LIMIT = 60'd1000000000000000000;

   typedef struct packed {
      logic start;
      logic shift;
   } rcd_dab_ctl_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic start;
   } rcd_pack_ctl_type;

   typedef struct packed {
      logic done;
      logic full;
   } rcd_pack_sts_type;

   function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      priority if (b < BASE_MIN) begin
         r = BASE_MIN;
      end else if (b > BASE_MAX) begin
         r = BASE_MAX;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/rcd_dabble.sv]
// Bit-serial binary to BCD shifter (shift and add three), then a digit shifter.
// Depends on rcd_pkg.
`default_nettype none

module rcd_dabble
   import rcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  rcd_dab_ctl_type      ctl,
   input  logic [IN_W-1:0]      bin,
   output logic                 done,
   output logic [DIGIT_W-1:0]   top_digit
);

   localparam int CNT_W = $clog2(IN_W);

   logic [BCD_W-1:0] bcd_ff, bcd_in, bcd_adj;
   logic [IN_W-1:0]  bin_ff, bin_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   // Each decimal digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      bcd_in  = bcd_ff;
      bin_in  = bin_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      priority if (ctl.start) begin
         bcd_in = '0;
         bin_in = bin;
         cnt_in = CNT_W'(IN_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         {bcd_in, bin_in} = {bcd_adj[BCD_W-2:0], bin_ff, 1'b0};
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end else if (ctl.shift) begin
         bcd_in = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end else begin
         bcd_in = bcd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

endmodule

`default_nettype wire

[rtl/core/rcd_divider.sv]
// Serial restoring divider of the value by the target base, four bits per cycle.
// Depends on rcd_pkg.
`default_nettype none

module rcd_divider
   import rcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [VAL_W-1:0]     dividend,
   input  logic [BASE_W-1:0]    divisor,
   output logic                 done,
   output logic [VAL_W-1:0]     quotient,
   output logic [BASE_W-1:0]    remainder
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic [DIV_W-1:0]  q_ff, q_in, q_step;
   logic [BASE_W-1:0] r_ff, r_in, r_step;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   // Dividend bits leave at the top of the word while quotient bits enter at the bottom.
   always_comb begin
      logic [BASE_W:0]   t;
      logic [BASE_W-1:0] r;
      logic [DIV_W-1:0]  q;
      r = r_ff;
      q = q_ff;
      for (int j = 0; j < DIV_CHUNK; j++) begin
         t = {r, q[DIV_W-1]};
         q = {q[DIV_W-2:0], 1'b0};
         if (t >= {1'b0, divisor}) begin
            r    = BASE_W'(t - {1'b0, divisor});
            q[0] = 1'b1;
         end else begin
            r = t[BASE_W-1:0];
         end
      end
      r_step = r;
      q_step = q;
   end

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      priority if (start) begin
         q_in   = {{(DIV_W - VAL_W){1'b0}}, dividend};
         r_in   = '0;
         cnt_in = CNT_W'(DIV_STEPS - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         q_in = q_step;
         r_in = r_step;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end else begin
         q_in = q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff[VAL_W-1:0];
   assign remainder = r_ff;

endmodule

`default_nettype wire

[rtl/core/rcd_packer.sv]
// Digit store for target-base digits and a serial times-ten accumulator that packs them.
// Depends on rcd_pkg.
`default_nettype none

module rcd_packer
   import rcd_pkg::*;
#(
   parameter int OUT_DIGITS = 18
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  rcd_pack_ctl_type     ctl,
   input  logic [DIGIT_W-1:0]   digit,
   output rcd_pack_sts_type     sts,
   output logic [OUT_W-1:0]     pack_num
);

   localparam int N_W = $clog2(OUT_DIGITS + 1);

   logic [DIGIT_W-1:0] dig_ff [OUT_DIGITS];
   logic [DIGIT_W-1:0] dig_in [OUT_DIGITS];
   logic [N_W-1:0]     n_ff, n_in;
   logic               run_ff, run_in;
   logic [OUT_W-1:0]   acc_ff, acc_in;

   // Digits arrive least significant first and enter at the top, so the most
   // significant digit sits at the top when packing starts.
   always_comb begin
      dig_in = dig_ff;
      n_in   = n_ff;
      run_in = run_ff;
      acc_in = acc_ff;
      priority if (ctl.clear) begin
         n_in   = '0;
         run_in = 1'b0;
      end else if (ctl.push) begin
         for (int i = 0; i < OUT_DIGITS - 1; i++) begin
            dig_in[i] = dig_ff[i+1];
         end
         dig_in[OUT_DIGITS-1] = digit;
         n_in = n_ff + 1'b1;
      end else if (ctl.start) begin
         acc_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (n_ff == '0) begin
            run_in = 1'b0;
         end else begin
            acc_in = (acc_ff << 3) + (acc_ff << 1) + OUT_W'(dig_ff[OUT_DIGITS-1]);
            for (int i = 1; i < OUT_DIGITS; i++) begin
               dig_in[i] = dig_ff[i-1];
            end
            n_in = n_ff - 1'b1;
         end
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff   <= '0;
         run_ff <= 1'b0;
      end else begin
         n_ff   <= n_in;
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
      acc_ff <= acc_in;
   end

   assign sts.done = run_ff && (n_ff == '0);
   assign sts.full = (n_ff == N_W'(OUT_DIGITS));
   assign pack_num = acc_ff;

endmodule

`default_nettype wire

[rtl/core/radix_converter_decimal_coded_top.sv]
// Radix converter for decimal-coded numbers: the decimal digits of req_coded_number are
// read as digits of the source base, the value is split into target-base digits, and those
// digits come back as the decimal digits of rsp_converted_number (zero, with rsp_overflow
// set, when more than OUT_DIGITS digits are needed). Items are worked one at a time. An
// item passes through the 30-step binary to BCD shifter and then the serial divider, which
// retires four bits of a 32-bit word per cycle for each target digit. A finished result
// waits in the output register while the next item is taken in. Base registers below 2
// act as 2 and above 10 act as 10; write them only while the block is idle.
// Depends on rcd_pkg, rcd_dabble, rcd_divider and rcd_packer.
`default_nettype none

module radix_converter_decimal_coded_top
   import rcd_pkg::*;
#(
   parameter int IN_DIGITS  = 9,
   parameter int OUT_DIGITS = 18
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [IN_W-1:0]      req_coded_number,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [OUT_W-1:0]     rsp_converted_number,
   output logic                 rsp_overflow,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BASE_W-1:0]    csr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DABBLE = 3'd1;
   localparam logic [2:0] S_WEIGH  = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_PACK   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   localparam int IDX_W  = $clog2(BCD_DIGITS);
   localparam int PROD_W = VAL_W + BASE_W;

   logic [2:0]        state_ff, state_in;
   logic [BASE_W-1:0] src_base_ff, src_base_in, tgt_base_ff, tgt_base_in;
   logic [BASE_W-1:0] src_base, tgt_base;
   logic [VAL_W-1:0]  value_ff, value_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_num_ff, rsp_num_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              out_free;

   rcd_dab_ctl_type   dab_ctl;
   logic              dab_done;
   logic [DIGIT_W-1:0] dab_digit, digit_kept;
   logic [PROD_W-1:0] weigh_wide;

   logic              div_start, div_done;
   logic [VAL_W-1:0]  div_q;
   logic [BASE_W-1:0] div_r;

   rcd_pack_ctl_type  pack_ctl;
   rcd_pack_sts_type  pack_sts;
   logic [OUT_W-1:0]  pack_num;

   rcd_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dab_ctl),
      .bin       (req_coded_number),
      .done      (dab_done),
      .top_digit (dab_digit)
   );

   rcd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (value_ff),
      .divisor   (tgt_base),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   rcd_packer #(
      .OUT_DIGITS (OUT_DIGITS)
   ) u_packer (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pack_ctl),
      .digit     (div_r),
      .sts       (pack_sts),
      .pack_num  (pack_num)
   );

   assign src_base_in = (csr_write && csr_index == CSR_SOURCE_BASE) ? csr_data : src_base_ff;
   assign tgt_base_in = (csr_write && csr_index == CSR_TARGET_BASE) ? csr_data : tgt_base_ff;
   assign src_base    = clamp_base(src_base_ff);
   assign tgt_base    = clamp_base(tgt_base_ff);

   // Horner step over the decimal digits, most significant first; digits above
   // IN_DIGITS are dropped. With nine kept digits the value stays below 1000000000, within VAL_W bits.
   assign digit_kept = (int'(idx_ff) < IN_DIGITS) ? dab_digit : '0;
   assign weigh_wide = PROD_W'(value_ff) * PROD_W'(src_base) + PROD_W'(digit_kept);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      dab_ctl      = '0;
      div_start    = 1'b0;
      pack_ctl     = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_num_in   = rsp_num_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dab_ctl.start  = 1'b1;
               pack_ctl.clear = 1'b1;
               ovf_in         = 1'b0;
               value_in       = '0;
               state_in       = S_DABBLE;
            end
         end
         S_DABBLE: begin
            if (dab_done) begin
               idx_in   = IDX_W'(BCD_DIGITS - 1);
               state_in = S_WEIGH;
            end
         end
         S_WEIGH: begin
            value_in      = weigh_wide[VAL_W-1:0];
            dab_ctl.shift = 1'b1;
            if (idx_ff == '0) begin
               state_in = S_CHECK;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         S_CHECK: begin
            priority if (value_ff == '0) begin
               pack_ctl.start = 1'b1;
               state_in       = S_PACK;
            end else if (pack_sts.full) begin
               ovf_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               value_in      = div_q;
               pack_ctl.push = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_PACK: begin
            if (pack_sts.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = ovf_ff ? '0 : pack_num;
               rsp_ovf_in   = ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         src_base_ff  <= SOURCE_BASE_RESET;
         tgt_base_ff  <= TARGET_BASE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         src_base_ff  <= src_base_in;
         tgt_base_ff  <= tgt_base_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      idx_ff     <= idx_in;
      ovf_ff     <= ovf_in;
      rsp_num_ff <= rsp_num_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_converted_number = rsp_num_ff;
   assign rsp_overflow         = rsp_ovf_ff;

endmodule

`default_nettype wire

[rtl/core/rcd_checker.sv]
// Port-level assertions for the radix converter and the bind that attaches them.
// Depends on rcd_pkg and radix_converter_decimal_coded_top_macros.svh.
`default_nettype none

`include "radix_converter_decimal_coded_top_macros.svh"

module rcd_checker
   import rcd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [OUT_W-1:0] rsp_converted_number,
   input  logic             rsp_overflow
);

   // An overflowed item carries no digits.
   `RCD_ASSERT_IMPLY(a_overflow_zero, clock, reset, rsp_valid && rsp_overflow, rsp_converted_number == '0)

   // At most eighteen decimal digits ever come out.
   `RCD_ASSERT_IMPLY(a_result_limit, clock, reset, rsp_valid, rsp_converted_number < RESULT_LIMIT)

   // Once an item is taken the block is busy with it.
   `RCD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   `RCD_ASSERT_NEXT(a_stalled_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_converted_number) && $stable(rsp_overflow))

endmodule

bind radix_converter_decimal_coded_top rcd_checker u_rcd_checker (.*);

`default_nettype wire
